// File: rtl/cache_set_lru_tag_match_top_assert.svh
// ---------------------------------------------------------------------------
// Cache set assertion macros
// Shared assertion forms for the cache set RTL, clocked on i_clk and
// disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CACHE_SET_LRU_TAG_MATCH_TOP_ASSERT_SVH
`define CACHE_SET_LRU_TAG_MATCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define CSL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("cache set check failed");

// Next-cycle implication.
`define CSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("cache set check failed");

`endif

// File: rtl/csl_pkg.sv
// ---------------------------------------------------------------------------
// Cache set package
// Sizes, request mode codes, controller states and the command and status
// bundles shared by the cache set modules.
// ---------------------------------------------------------------------------
package csl_pkg;

    localparam int WAYS      = 8;
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int IDX_BITS  = 3;
    localparam int TAG_BITS  = 32;
    localparam int CNT_BITS  = 32;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_TOUCH  = 2'd1,
        MODE_ALLOC  = 2'd2,
        MODE_ACCESS = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

// File: rtl/cache_set_lru_tag_match_top.sv
// One set of an eight-way set-associative cache with true LRU replacement.
// Each request is handled in two steps: it is captured, then the compare
// and LRU shift chain updates the set and loads the output register; no new
// request is captured before the last one commits. The output register lets the
// next request be captured while a result still waits to be taken; a held
// result delays only the update step. Configuration writes are taken at any
// time but are meant to happen while the block is idle.
// ---------------------------------------------------------------------------
// Cache set top level
// Connects the request controller and the set datapath to the ports.
// ---------------------------------------------------------------------------
module cache_set_lru_tag_match_top
    import csl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic [IDX_BITS-1:0] i_way_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_hit,
    output logic [IDX_BITS-1:0] o_hit_way,
    output logic [IDX_BITS-1:0] o_victim_way,
    output logic [CNT_BITS-1:0] o_usage_count
);

    t_cmd cmd;
    t_sts sts;

    csl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    csl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_mode        (i_mode),
        .i_tag         (i_tag),
        .i_way_index   (i_way_index),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_hit_way     (o_hit_way),
        .o_victim_way  (o_victim_way),
        .o_usage_count (o_usage_count)
    );

endmodule

// File: rtl/csl_ctrl.sv
// ---------------------------------------------------------------------------
// Cache set controller
// Two-state sequencer: capture a request, then commit it to the set state
// and the output register once that register can take a result.
// ---------------------------------------------------------------------------
`include "cache_set_lru_tag_match_top_assert.svh"

module csl_ctrl
    import csl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   out_free;

    assign out_free = !i_sts.out_full || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall     = 1'b1;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    `CSL_ASSERT_NEXT(a_capture_then_exec, o_cmd.capture, r_state == ST_EXEC)
    `CSL_ASSERT_SAME(a_commit_needs_room, o_cmd.commit, !i_sts.out_full || !i_out_stall)
    `CSL_ASSERT_SAME(a_exec_stalls_input, r_state == ST_EXEC, o_in_stall)

endmodule

// File: rtl/csl_dp.sv
// ---------------------------------------------------------------------------
// Cache set datapath
// Holds tags, valid bits, the LRU order list and the access counter, runs
// the parallel tag compare and LRU shift chain, and keeps the output register.
// ---------------------------------------------------------------------------
`include "cache_set_lru_tag_match_top_assert.svh"

module csl_dp
    import csl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic [1:0]          i_mode,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic [IDX_BITS-1:0] i_way_index,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_hit,
    output logic [IDX_BITS-1:0] o_hit_way,
    output logic [IDX_BITS-1:0] o_victim_way,
    output logic [CNT_BITS-1:0] o_usage_count
);

    logic                r_wb;
    t_mode               r_mode;
    logic [TAG_BITS-1:0] r_tag;
    logic [IDX_BITS-1:0] r_way;

    logic [TAG_BITS-1:0] r_tags [WAYS];
    logic [WAYS-1:0]     r_valid;
    logic [WAY_BITS-1:0] r_lru  [WAYS];
    logic [WAY_BITS-1:0] n_lru  [WAYS];
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    logic                r_out_valid;
    logic                r_hit;
    logic [IDX_BITS-1:0] r_hit_way;
    logic [IDX_BITS-1:0] r_victim;

    logic                way_ok;
    logic [WAYS-1:0]     tag_eq;
    logic                lk_hit;
    logic [IDX_BITS-1:0] lk_way;
    logic [WAYS-1:0]     pos_eq;
    logic [WAYS-1:0]     seen;

    assign way_ok = ({1'b0, r_way} < (IDX_BITS + 1)'(WAYS));

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            tag_eq[i] = r_valid[i] && (r_tags[i] == r_tag);
        end
        lk_hit = |tag_eq;
        lk_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (tag_eq[i]) begin
                lk_way = IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            pos_eq[k] = way_ok && (r_lru[k] == r_way[WAY_BITS-1:0]);
        end
        seen[0] = pos_eq[0];
        for (int k = 1; k < WAYS; k++) begin
            seen[k] = seen[k-1] | pos_eq[k];
        end
        for (int k = 0; k < WAYS; k++) begin
            n_lru[k] = r_lru[k];
        end
        if (r_mode == MODE_TOUCH) begin
            for (int k = 0; k < WAYS - 1; k++) begin
                if (seen[k]) begin
                    n_lru[k] = r_lru[k+1];
                end
            end
            if (seen[WAYS-1]) begin
                n_lru[WAYS-1] = r_way[WAY_BITS-1:0];
            end
        end
    end

    assign n_count = (r_mode == MODE_ACCESS) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= 1'b1;
        end else if (i_cfg_we) begin
            r_wb <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_mode'(i_mode);
            r_tag  <= i_tag;
            r_way  <= i_way_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_mode == MODE_ALLOC && r_wb && way_ok) begin
            r_tags[r_way[WAY_BITS-1:0]] <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int k = 0; k < WAYS; k++) begin
                r_lru[k] <= WAY_BITS'(k);
            end
        end else if (i_cmd.commit) begin
            if (r_mode == MODE_ALLOC && r_wb && way_ok) begin
                r_valid[r_way[WAY_BITS-1:0]] <= 1'b1;
            end
            r_count <= n_count;
            for (int k = 0; k < WAYS; k++) begin
                r_lru[k] <= n_lru[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit     <= (r_mode == MODE_LOOKUP) && lk_hit;
            r_hit_way <= (r_mode == MODE_LOOKUP) ? lk_way : '0;
            r_victim  <= IDX_BITS'(n_lru[0]);
        end
    end

    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_hit_way      = r_hit_way;
    assign o_victim_way   = r_victim;
    assign o_usage_count  = r_count;

    `CSL_ASSERT_NEXT(a_commit_loads_out, i_rst_n && i_cmd.commit, r_out_valid)
    `CSL_ASSERT_NEXT(a_count_only_access,
        i_rst_n && i_cmd.commit && r_mode != MODE_ACCESS, r_count == $past(r_count))
    `CSL_ASSERT_NEXT(a_touch_to_mru,
        i_rst_n && i_cmd.commit && r_mode == MODE_TOUCH && way_ok,
        r_lru[WAYS-1] == $past(r_way[WAY_BITS-1:0]))

endmodule
